>>> rtl/qsv_pkg.sv
// ----------------------------------------------------------------------------
// qsv_pkg
// Shared types and constants for the state vector gate engine.
// ----------------------------------------------------------------------------
package qsv_pkg;

  localparam int MaxQubitsDef = 5;
  localparam int AmpWidthDef  = 18;

  localparam int AngW  = 16;
  localparam int TW    = 20;               // half-angle in 2^-16 rad
  localparam int CW    = 19;               // CORDIC x/y width
  localparam int MW    = 19;               // matrix entry width, Q2.16 signed
  localparam int CordicSteps = 16;

  localparam logic signed [TW-1:0] PiQ16     = 20'sd205887;
  localparam logic signed [TW-1:0] HalfPiQ16 = 20'sd102944;
  localparam logic signed [CW-1:0] GainQ16   = 19'sd39797;
  localparam logic signed [MW-1:0] OneQ16    = 19'sd65536;
  localparam logic signed [MW-1:0] InvSqrt2  = 19'sd46341;

  typedef enum logic [2:0] {
    GATE_X  = 3'd0,
    GATE_Y  = 3'd1,
    GATE_Z  = 3'd2,
    GATE_H  = 3'd3,
    GATE_S  = 3'd4,
    GATE_RX = 3'd5,
    GATE_RY = 3'd6,
    GATE_RZ = 3'd7
  } gate_t;

  // Classified command handed from front end to back end.
  typedef struct packed {
    logic                  restart;
    logic [2:0]            qubit;
    gate_t                 kind;
    logic signed [AngW-1:0] angle;
  } cmd_t;

  function automatic logic signed [TW-1:0] atan_q16(input logic [3:0] i);
    logic signed [TW-1:0] r;
    case (i)
      4'd0:  r = 20'sd51472;
      4'd1:  r = 20'sd30385;
      4'd2:  r = 20'sd16055;
      4'd3:  r = 20'sd8150;
      4'd4:  r = 20'sd4091;
      4'd5:  r = 20'sd2047;
      4'd6:  r = 20'sd1024;
      4'd7:  r = 20'sd512;
      4'd8:  r = 20'sd256;
      4'd9:  r = 20'sd128;
      4'd10: r = 20'sd64;
      4'd11: r = 20'sd32;
      4'd12: r = 20'sd16;
      4'd13: r = 20'sd8;
      4'd14: r = 20'sd4;
      4'd15: r = 20'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/qsv_front.sv
// ----------------------------------------------------------------------------
// qsv_front
// Accepts input transactions, drops invalid gates, queues commands.
// ----------------------------------------------------------------------------
module qsv_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_action,
  input  logic [2:0]              in_target_qubit,
  input  logic [2:0]              in_gate_kind,
  input  logic signed [15:0]      in_angle,
  input  logic [2:0]              eff_qubits,
  output logic                    cmd_valid,
  input  logic                    cmd_take,
  output qsv_pkg::cmd_t           cmd
);
  import qsv_pkg::*;

  // two-entry queue
  cmd_t       q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  logic       acc, push;
  cmd_t       c_in;

  assign in_stall  = (cnt_r == 2'd2);
  assign acc       = in_valid && !in_stall;
  assign c_in.restart = in_action;
  assign c_in.qubit   = in_target_qubit;
  assign c_in.kind    = gate_t'(in_gate_kind);
  assign c_in.angle   = in_angle;
  // gates on qubits outside the vector are dropped here
  assign push = acc && (in_action || (in_target_qubit < eff_qubits));

  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, cmd_take};
    rd_nxt  = rd_r ^ cmd_take;
    wr_nxt  = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (push) q_r[wr_r] <= c_in;
  end

endmodule

>>> rtl/qsv_back.sv
// ----------------------------------------------------------------------------
// qsv_back
// Runs CORDIC, the pair update walk and the probability readout.
// ----------------------------------------------------------------------------
module qsv_back #(
  parameter int MAX_QUBITS = qsv_pkg::MaxQubitsDef,
  parameter int AMP_WIDTH  = qsv_pkg::AmpWidthDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [2:0]             eff_qubits,
  input  logic                   cfg_clear,
  input  logic                   cmd_valid,
  output logic                   cmd_take,
  input  qsv_pkg::cmd_t          cmd,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [4:0]             out_basis_index,
  output logic [15:0]            out_probability,
  output logic                   out_last
);
  import qsv_pkg::*;

  localparam int Depth = 1 << MAX_QUBITS;
  localparam int IW    = MAX_QUBITS;
  localparam int CntW  = MAX_QUBITS + 1;
  localparam int PW    = 2 * AMP_WIDTH + 1;
  localparam int SW    = MW + AMP_WIDTH + 3;   // sum of four products
  localparam int QW    = (MAX_QUBITS > 1) ? $clog2(MAX_QUBITS) : 1;
  localparam logic signed [AMP_WIDTH-1:0] AmpMax = {1'b0, {(AMP_WIDTH-1){1'b1}}};
  localparam logic signed [AMP_WIDTH-1:0] AmpMin = {1'b1, {(AMP_WIDTH-1){1'b0}}};

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLR   = 9'b000000010,
    S_CORD  = 9'b000000100,
    S_RD0   = 9'b000001000,
    S_RD1   = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_WR0   = 9'b001000000,
    S_WR1   = 9'b010000000,
    S_OUT   = 9'b100000000
  } st_t;

  function automatic logic signed [AMP_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + SW'(32768)) >>> 16;
    if (r > SW'(AmpMax)) return AmpMax;
    if (r < SW'(AmpMin)) return AmpMin;
    return r[AMP_WIDTH-1:0];
  endfunction

  function automatic logic signed [AMP_WIDTH-1:0] sat_one();
    if (AMP_WIDTH >= 18) return AMP_WIDTH'(65536);
    return AmpMax;
  endfunction

  st_t st_r, st_nxt;

  // amplitude memory: real and imaginary parts side by side
  logic [2*AMP_WIDTH-1:0] mem [Depth];
  logic [2*AMP_WIDTH-1:0] rdata_r;
  logic                   we;
  logic [IW-1:0]          waddr, raddr;
  logic [2*AMP_WIDTH-1:0] wdata;

  logic [CntW-1:0] i_r;          // general counter
  logic [IW-1:0]   stride_r;
  gate_t           kind_r;
  logic signed [CW-1:0] x_r, y_r;
  logic signed [TW-1:0] z_r;
  logic            flip_r;
  logic signed [AMP_WIDTH-1:0] a0re_r, a0im_r;
  logic signed [AMP_WIDTH-1:0] n1re_r, n1im_r;
  logic signed [SW-1:0] s0re_r, s0im_r, s1re_r, s1im_r;
  logic [IW-1:0] p0_r;
  logic [IW-1:0] lo_mask;
  logic [IW-1:0] idx0, idx1;
  logic [CntW-1:0] size;
  logic signed [MW-1:0] m0re, m0im, m1re, m1im, m2re, m2im, m3re, m3im;
  logic signed [MW-1:0] c_q, s_q;
  logic obuf_full_r;
  logic [4:0] ob_idx_r;
  logic [15:0] ob_p_r;
  logic ob_last_r;
  logic rd_pend_r;
  logic [CntW-1:0] ri_r;
  logic signed [AMP_WIDTH-1:0] pre, pim;
  logic [PW-1:0] psum;
  logic [PW-1:0] pq;
  logic out_go;
  logic signed [CW-1:0] xs, ys;
  logic [3:0] step;

  assign size    = CntW'(1) << eff_qubits;
  assign lo_mask = stride_r - IW'(1);
  // pair k: insert a zero at the stride bit
  assign idx0 = ((i_r[IW-1:0] & ~lo_mask) << 1) | (i_r[IW-1:0] & lo_mask);
  assign idx1 = idx0 | stride_r;
  assign step = i_r[3:0];
  assign xs = x_r >>> step;
  assign ys = y_r >>> step;
  assign c_q = flip_r ? -x_r : x_r;
  assign s_q = flip_r ? -y_r : y_r;

  always_comb begin
    {m0re, m0im, m1re, m1im, m2re, m2im, m3re, m3im} = '0;
    case (kind_r)
      GATE_X:  begin m1re = OneQ16; m2re = OneQ16; end
      GATE_Y:  begin m1im = -OneQ16; m2im = OneQ16; end
      GATE_Z:  begin m0re = OneQ16; m3re = -OneQ16; end
      GATE_H:  begin m0re = InvSqrt2; m1re = InvSqrt2; m2re = InvSqrt2;
                     m3re = -InvSqrt2; end
      GATE_S:  begin m0re = OneQ16; m3im = OneQ16; end
      GATE_RX: begin m0re = c_q; m1im = -s_q; m2im = -s_q; m3re = c_q; end
      GATE_RY: begin m0re = c_q; m1re = -s_q; m2re = s_q; m3re = c_q; end
      GATE_RZ: begin m0re = c_q; m0im = -s_q; m3re = c_q; m3im = s_q; end
      default: ;
    endcase
  end

  assign out_go  = obuf_full_r && !out_stall;
  assign out_valid       = obuf_full_r;
  assign out_basis_index = ob_idx_r;
  assign out_probability = ob_p_r;
  assign out_last        = ob_last_r;

  assign pre  = rdata_r[2*AMP_WIDTH-1:AMP_WIDTH];
  assign pim  = rdata_r[AMP_WIDTH-1:0];
  assign psum = PW'((pre * pre)) + PW'((pim * pim)) + PW'(32768);
  assign pq   = psum >> 16;

  always_comb begin
    st_nxt   = st_r;
    cmd_take = 1'b0;
    we    = 1'b0;
    waddr = i_r[IW-1:0];
    wdata = '0;
    raddr = idx0;
    case (st_r)
      S_IDLE: begin
        if (cfg_clear) st_nxt = S_CLR;
        else if (cmd_valid) begin
          cmd_take = 1'b1;
          if (cmd.restart) st_nxt = S_CLR;
          else if (cmd.kind == GATE_RX || cmd.kind == GATE_RY ||
                   cmd.kind == GATE_RZ) st_nxt = S_CORD;
          else st_nxt = S_RD0;
        end
      end
      S_CLR: begin
        we = 1'b1;
        wdata = (i_r == '0) ? {sat_one(), {AMP_WIDTH{1'b0}}} : '0;
        if (i_r == CntW'(Depth - 1)) st_nxt = S_IDLE;
      end
      S_CORD: if (i_r == CntW'(CordicSteps - 1)) st_nxt = S_RD0;
      S_RD0: begin raddr = idx0; st_nxt = S_RD1; end
      S_RD1: begin raddr = idx1; st_nxt = S_MUL; end
      S_MUL: st_nxt = S_WR0;
      S_WR0: begin
        we = 1'b1; waddr = p0_r;
        wdata = {sat(s0re_r), sat(s0im_r)};
        st_nxt = S_WR1;
      end
      S_WR1: begin
        we = 1'b1; waddr = p0_r | stride_r;
        wdata = {n1re_r, n1im_r};
        if (i_r == (size >> 1) - CntW'(1)) st_nxt = S_OUT;
        else st_nxt = S_RD0;
      end
      S_OUT: begin
        raddr = ri_r[IW-1:0];
        if (out_go && ob_last_r) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      i_r  <= '0;
      obuf_full_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      ri_r        <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        S_IDLE: begin
          i_r <= '0;
          if (!cfg_clear && cmd_valid) begin
            kind_r   <= cmd.kind;
            stride_r <= IW'((CntW'(1) << (eff_qubits - 3'd1)) >> cmd.qubit[QW-1:0]);
            // half angle, folded into [-pi/2, pi/2]
            begin
              if ((TW'(cmd.angle) <<< 3) > HalfPiQ16) begin
                z_r <= (TW'(cmd.angle) <<< 3) - PiQ16; flip_r <= 1'b1;
              end else if ((TW'(cmd.angle) <<< 3) < -HalfPiQ16) begin
                z_r <= (TW'(cmd.angle) <<< 3) + PiQ16; flip_r <= 1'b1;
              end else begin
                z_r <= TW'(cmd.angle) <<< 3; flip_r <= 1'b0;
              end
            end
            x_r <= GainQ16;
            y_r <= '0;
          end
        end
        S_CLR: i_r <= (i_r == CntW'(Depth - 1)) ? '0 : i_r + CntW'(1);
        S_CORD: begin
          if (z_r >= 0) begin
            x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - atan_q16(step);
          end else begin
            x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + atan_q16(step);
          end
          i_r <= (i_r == CntW'(CordicSteps - 1)) ? '0 : i_r + CntW'(1);
        end
        S_RD0: p0_r <= idx0;
        S_RD1: begin
          a0re_r <= pre; a0im_r <= pim;
        end
        S_MUL: begin
          s0re_r <= SW'(m0re * a0re_r) - SW'(m0im * a0im_r)
                  + SW'(m1re * pre) - SW'(m1im * pim);
          s0im_r <= SW'(m0re * a0im_r) + SW'(m0im * a0re_r)
                  + SW'(m1re * pim) + SW'(m1im * pre);
          s1re_r <= SW'(m2re * a0re_r) - SW'(m2im * a0im_r)
                  + SW'(m3re * pre) - SW'(m3im * pim);
          s1im_r <= SW'(m2re * a0im_r) + SW'(m2im * a0re_r)
                  + SW'(m3re * pim) + SW'(m3im * pre);
        end
        S_WR0: begin
          n1re_r <= sat(s1re_r); n1im_r <= sat(s1im_r);
        end
        S_WR1: begin
          i_r  <= (st_nxt == S_OUT) ? '0 : i_r + CntW'(1);
          ri_r <= '0;
          rd_pend_r <= 1'b0;
        end
        S_OUT: begin
          // readout: address issued, read data registered, then loaded into out buffer
          if (!rd_pend_r && !obuf_full_r && ri_r < size) begin
            rd_pend_r <= 1'b1;
          end else if (rd_pend_r) begin
            rd_pend_r   <= 1'b0;
            obuf_full_r <= 1'b1;
            ob_idx_r    <= 5'(ri_r);
            ob_p_r      <= (pq > PW'(65535)) ? 16'hFFFF : pq[15:0];
            ob_last_r   <= (ri_r == size - CntW'(1));
            ri_r        <= ri_r + CntW'(1);
          end
        end
        default: ;
      endcase
      if (out_go) obuf_full_r <= 1'b0;
    end
  end

endmodule

>>> rtl/qubit_state_vector_gate_engine_top.sv
// ----------------------------------------------------------------------------
// qubit_state_vector_gate_engine_top
// Single-qubit gate engine on a fixed-point complex state vector.
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  in      | in_valid/in_stall, action, target, kind, angle | into block
//  out     | out_valid/out_stall, basis_index, prob, last    | out of block
//  cfg     | cfg_wr_en, cfg_wr_data (num_qubits)             | into block
//
//  A gate is taken, CORDIC iterates for RX/RY/RZ, then each amplitude pair
//  is processed in turn (two reads, multiply, two writes); then each
//  probability result is read, loaded into the single output buffer and
//  handed off, the next read waiting until that buffer is empty.
//  After reset, a restart, or a cfg write, a clearing pass rewrites all
//  2^MAX_QUBITS memory entries. Front end queue holds two transactions, so
//  input is taken while the back end works or waits on out_stall.
// ----------------------------------------------------------------------------
module qubit_state_vector_gate_engine_top #(
  parameter int MAX_QUBITS = qsv_pkg::MaxQubitsDef,
  parameter int AMP_WIDTH  = qsv_pkg::AmpWidthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [2:0]         in_target_qubit,
  input  logic [2:0]         in_gate_kind,
  input  logic signed [15:0] in_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_basis_index,
  output logic [15:0]        out_probability,
  output logic               out_last
);
  import qsv_pkg::*;

  logic [2:0] nq_r;
  logic [2:0] eff;
  logic       clr_r;
  logic       cmd_valid, cmd_take;
  cmd_t       cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nq_r  <= 3'd1;
      clr_r <= 1'b0;
    end else begin
      if (cfg_wr_en) nq_r <= cfg_wr_data;
      clr_r <= cfg_wr_en;   // user keeps block idle on writes (unenforced)
    end
  end

  // clamp qubit count to [1, MAX_QUBITS]
  assign eff = (nq_r == 3'd0) ? 3'd1 :
               ({29'd0, nq_r} > 32'(MAX_QUBITS)) ? 3'(MAX_QUBITS) : nq_r;

  qsv_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_target_qubit,
    .in_gate_kind, .in_angle, .eff_qubits(eff),
    .cmd_valid, .cmd_take, .cmd
  );

  qsv_back #(.MAX_QUBITS(MAX_QUBITS), .AMP_WIDTH(AMP_WIDTH)) u_back (
    .clk, .rst_n, .eff_qubits(eff), .cfg_clear(clr_r),
    .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_stall, .out_basis_index, .out_probability, .out_last
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the state vector gate engine: a table of directed
// gates, then random gate sequences, all checked against a behavioural
// predictor of the amplitude vector and its probabilities.
// ----------------------------------------------------------------------------
module tb_top;
  import qsv_pkg::*;

  localparam int NQMax      = 5;
  localparam int AmpW       = 18;
  localparam int VecDepth   = 1 << NQMax;
  localparam int WdogLimit  = 20000;
  localparam int TailCycles = 400;
  localparam int RandItems  = 330;
  localparam int NumDir     = 20;

  // action codes
  localparam logic ActGate    = 1'b0;
  localparam logic ActRestart = 1'b1;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [2:0]        cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic              in_action;
  logic [2:0]        in_target_qubit;
  logic [2:0]        in_gate_kind;
  logic signed [15:0] in_angle;
  logic              out_valid;
  logic              out_stall;
  logic [4:0]        out_basis_index;
  logic [15:0]       out_probability;
  logic              out_last;

  qubit_state_vector_gate_engine_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_target_qubit (in_target_qubit),
    .in_gate_kind    (in_gate_kind),
    .in_angle        (in_angle),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_basis_index (out_basis_index),
    .out_probability (out_probability),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: shadow amplitude vector plus the qubit count register.
  // --------------------------------------------------------------------------
  typedef struct {
    logic [4:0]  idx;
    logic [15:0] prob;
    logic        last;
  } prob_rec_t;

  longint    amp_re [VecDepth];
  longint    amp_im [VecDepth];
  logic [2:0] qubit_reg;
  prob_rec_t prob_q[$];

  int  err_count;
  bit  timed_out;
  bit  stim_done;
  bit  hold_off;

  function automatic longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat_amp(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (AmpW - 1)) - 1;
    lo = -(longint'(1) <<< (AmpW - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic int active_qubits();
    if (qubit_reg < 1) return 1;
    if (qubit_reg > NQMax) return NQMax;
    return int'(qubit_reg);
  endfunction

  task automatic clear_amps();
    for (int i = 0; i < VecDepth; i++) begin
      amp_re[i] = 0;
      amp_im[i] = 0;
    end
    amp_re[0] = sat_amp(65536);
  endtask

  task automatic half_angle_trig(input longint t, output longint c, output longint s);
    longint x, y, z, nx;
    longint atn [16];
    bit flip;
    atn = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2};
    x = 39797; y = 0; z = t; flip = 0;
    if (z > 102944) begin
      z -= 205887; flip = 1;
    end else if (z < -102944) begin
      z += 205887; flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - fl_shr(y, i); y = y + fl_shr(x, i); z -= atn[i];
      end else begin
        nx = x + fl_shr(y, i); y = y - fl_shr(x, i); z += atn[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // Apply one accepted transaction to the shadow vector, queue probabilities.
  task automatic predict_gate(input logic act, input logic [2:0] tq, input gate_t kind,
                              input logic signed [15:0] ang);
    longint mr [4];
    longint mi [4];
    longint c, s, re, im, ar0, ai0, ar1, ai1, p;
    int nq, vsize, stride, j;
    prob_rec_t r;
    nq = active_qubits();
    vsize = 1 << nq;
    if (act == ActRestart) begin
      clear_amps();
      return;
    end
    if (int'(tq) >= nq) return;
    for (int k = 0; k < 4; k++) begin
      mr[k] = 0; mi[k] = 0;
    end
    c = 0; s = 0;
    if (kind inside {GATE_RX, GATE_RY, GATE_RZ})
      half_angle_trig(longint'(ang) * 8, c, s);
    case (kind)
      GATE_X:  begin mr[1] = 65536; mr[2] = 65536; end
      GATE_Y:  begin mi[1] = -65536; mi[2] = 65536; end
      GATE_Z:  begin mr[0] = 65536; mr[3] = -65536; end
      GATE_H:  begin mr[0] = 46341; mr[1] = 46341; mr[2] = 46341; mr[3] = -46341; end
      GATE_S:  begin mr[0] = 65536; mi[3] = 65536; end
      GATE_RX: begin mr[0] = c; mi[1] = -s; mi[2] = -s; mr[3] = c; end
      GATE_RY: begin mr[0] = c; mr[1] = -s; mr[2] = s; mr[3] = c; end
      default: begin mr[0] = c; mi[0] = -s; mr[3] = c; mi[3] = s; end
    endcase
    stride = 1 << (nq - 1 - int'(tq));
    for (int i = 0; i < vsize; i++) begin
      if ((i & stride) == 0) begin
        j = i | stride;
        ar0 = amp_re[i]; ai0 = amp_im[i]; ar1 = amp_re[j]; ai1 = amp_im[j];
        for (int h = 0; h < 2; h++) begin
          re = mr[2*h]*ar0 - mi[2*h]*ai0 + mr[2*h+1]*ar1 - mi[2*h+1]*ai1;
          im = mr[2*h]*ai0 + mi[2*h]*ar0 + mr[2*h+1]*ai1 + mi[2*h+1]*ar1;
          amp_re[h ? j : i] = sat_amp(fl_shr(re + 32768, 16));
          amp_im[h ? j : i] = sat_amp(fl_shr(im + 32768, 16));
        end
      end
    end
    for (int i = 0; i < vsize; i++) begin
      p = (amp_re[i]*amp_re[i] + amp_im[i]*amp_im[i] + 32768) >>> 16;
      if (p > 65535) p = 65535;
      r.idx  = 5'(i);
      r.prob = 16'(p);
      r.last = (i == vsize - 1);
      prob_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
  endtask

  // --------------------------------------------------------------------------
  // Directed table. exp_p0 >= 0 gives a hand value for basis 0's probability
  // where it is obvious; the predictor still checks every row.
  // --------------------------------------------------------------------------
  typedef struct {
    logic        act;
    logic [2:0]  tq;
    gate_t       kind;
    logic signed [15:0] ang;
    int          exp_p0;
  } dir_row_t;

  dir_row_t dir_tab [NumDir];
  int       hand_p0_q[$];

  initial begin
    dir_tab = '{
      '{ActGate,    3'd0, GATE_Z,  16'sd0,      65535}, // fresh state stays |0>
      '{ActGate,    3'd0, GATE_X,  16'sd0,      0},
      '{ActGate,    3'd0, GATE_Y,  16'sd0,      65535},
      '{ActGate,    3'd0, GATE_H,  16'sd0,      -1},
      '{ActGate,    3'd0, GATE_S,  16'sd0,      -1},
      '{ActGate,    3'd1, GATE_X,  16'sd0,      -1},    // target out of range
      '{ActGate,    3'd7, GATE_H,  16'sd0,      -1},
      '{ActRestart, 3'd5, GATE_RZ, -16'sd1,     -1},
      '{ActGate,    3'd0, GATE_RX, 16'sd12868,  -1},    // about pi
      '{ActGate,    3'd0, GATE_RY, 16'sd32767,  -1},
      '{ActGate,    3'd0, GATE_RZ, -16'sd32768, -1},
      '{ActGate,    3'd0, GATE_RY, 16'sd6434,   -1},    // about pi/2
      '{ActGate,    3'd0, GATE_RX, -16'sd6434,  -1},
      '{ActGate,    3'd0, GATE_RY, 16'sd0,      -1},
      '{ActGate,    3'd0, GATE_RZ, 16'sd25736,  -1},
      '{ActRestart, 3'd0, GATE_X,  16'sd0,      -1},
      '{ActGate,    3'd0, GATE_H,  16'sd0,      32768},
      '{ActGate,    3'd0, GATE_H,  16'sd0,      -1},
      '{ActGate,    3'd0, GATE_RY, 16'sd12867,  -1},
      '{ActGate,    3'd0, GATE_RX, -16'sd1,     -1}
    };
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  task automatic send_item(input logic act, input logic [2:0] tq, input gate_t kind,
                           input logic signed [15:0] ang);
    in_valid        <= 1'b1;
    in_action       <= act;
    in_target_qubit <= tq;
    in_gate_kind    <= kind;
    in_angle        <= ang;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_gate(act, tq, kind, ang);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int n;
    if ($urandom_range(0, 2) == 0) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // waits for all expectations to drain, then the block's tail latency
  task automatic wait_idle();
    while (prob_q.size() != 0 && !timed_out) @(negedge clk);
    repeat (TailCycles) @(negedge clk);
  endtask

  task automatic write_qubits(input logic [2:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    qubit_reg = v;
    clear_amps();
    repeat (VecDepth + 4) @(negedge clk);   // clearing pass
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 16'sh8000 | 16'($urandom_range(0, 3));
      1: return 16'sh7FFC | 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int nq;
    logic [2:0] tq;
    logic [2:0] qsettings [6];
    qsettings = '{3'd2, 3'd5, 3'd0, 3'd7, 3'd3, 3'd4};
    err_count = 0; timed_out = 0; stim_done = 0; hold_off = 0;
    rst_n = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0;
    in_valid = 1'b0; in_action = 1'b0; in_target_qubit = '0;
    in_gate_kind = '0; in_angle = '0;
    qubit_reg = 3'd1;
    clear_amps();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    repeat (VecDepth + 4) @(negedge clk);

    // directed table at reset qubit count (one qubit)
    for (int k = 0; k < NumDir; k++) begin
      if (dir_tab[k].act == ActGate && int'(dir_tab[k].tq) < active_qubits())
        hand_p0_q.push_back(dir_tab[k].exp_p0);
      send_item(dir_tab[k].act, dir_tab[k].tq, dir_tab[k].kind, dir_tab[k].ang);
      sender_gap();
    end
    in_valid <= 1'b0;
    wait_idle();

    // random phases across qubit count settings
    for (int ph = 0; ph < 6; ph++) begin
      write_qubits(qsettings[ph]);
      nq = active_qubits();
      // mostly small vectors; the five-qubit phases are kept short
      for (int k = 0; k < ((nq == 5) ? 25 : RandItems / 5); k++) begin
        if (ph == 1 && k == 3) hold_off = 1;
        tq = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(nq, 7))
                                          : 3'($urandom_range(0, nq - 1));
        if ($urandom_range(0, 19) == 0)
          send_item(ActRestart, 3'($urandom), gate_t'($urandom), 16'($urandom));
        else
          send_item(ActGate, tq, gate_t'($urandom_range(0, 7)), rand_angle());
        sender_gap();
      end
      in_valid <= 1'b0;
      wait_idle();
    end
    stim_done = 1;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall with a single long hold-off to fill the block.
  // --------------------------------------------------------------------------
  initial begin
    int n;
    bit held;
    out_stall = 1'b0;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_off && !held) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (600) @(negedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    prob_rec_t w;
    int hp;
    if (rst_n && out_valid && !out_stall) begin
      if (prob_q.size() == 0) begin
        report_mismatch("unexpected result basis", out_basis_index, -1);
      end else begin
        w = prob_q.pop_front();
        if (out_basis_index !== w.idx) report_mismatch("basis_index", out_basis_index, w.idx);
        if (out_probability !== w.prob) report_mismatch("probability", out_probability, w.prob);
        if (out_last !== w.last) report_mismatch("last", out_last, w.last);
        if (w.idx == 0 && hand_p0_q.size() != 0) begin
          hp = hand_p0_q.pop_front();
          if (hp >= 0 && out_probability !== 16'(hp))
            report_mismatch("hand probability", out_probability, hp);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on any channel and no reset; also ends the run
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en || !rst_n)
        idle = 0;
      else
        idle++;
      if (stim_done) begin
        if (prob_q.size() != 0) err_count++;
        if (err_count == 0)
          $display("status: pass");
        else
          $display("status: fail");
        $finish;
      end else if (idle >= WdogLimit) begin
        timed_out = 1;
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
